[rtl/core/landmark_association_gate_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the landmark association gate
// ---------------------------------------------------------------------------
`ifndef LANDMARK_ASSOCIATION_GATE_MACROS_SVH
`define LANDMARK_ASSOCIATION_GATE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check an expression at every clock edge outside reset.
`define LAG_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define LAG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define LAG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LAG_ASSERT(lbl, expr, msg)
`define LAG_ASSERT_IMP(lbl, ante, cons, msg)
`define LAG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/lag_pkg.sv]
// ---------------------------------------------------------------------------
// lag_pkg
// Types, constants and the arctangent table of the landmark association gate.
// ---------------------------------------------------------------------------
`default_nettype none
package lag_pkg;

  localparam int unsigned MaxLandmarksDef = 64;
  localparam int unsigned CoordWidth      = 32;
  localparam int unsigned WorldWidth      = CoordWidth + 2;
  localparam int unsigned CordicWidth     = 34;
  localparam int unsigned CordicSteps     = 16;
  localparam int unsigned GateWidth       = 31;

  localparam logic signed [17:0] PiQ13     = 18'sd25736;
  localparam logic signed [17:0] HalfPiQ13 = 18'sd12868;
  localparam logic signed [17:0] TwoPiQ13  = 18'sd51472;
  localparam logic signed [CordicWidth-1:0] CordicGain = 34'sh026DD3B6A;
  localparam logic [GateWidth-1:0] GateReset = 31'd65536;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } lag_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_SCAN
  } lag_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ROT,
    PH_MUL,
    PH_ADD
  } lag_phase_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [31:0]      mark_x;
    logic signed [31:0]      mark_y;
    logic signed [31:0]      pose_x;
    logic signed [31:0]      pose_y;
    logic signed [15:0]      pose_heading;
    logic [30:0]             meas_range;
    logic signed [15:0]      meas_bearing;
  } lag_req_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic signed [31:0] match_x;
    logic signed [31:0] match_y;
    logic [5:0]         match_index;
  } lag_rsp_t;

  function automatic logic [CordicWidth-1:0] atan_q30(input logic [3:0] idx);
    logic [CordicWidth-1:0] v;
    case (idx)
      4'd0:  v = 34'h03243F6A8;
      4'd1:  v = 34'h01DAC6705;
      4'd2:  v = 34'h00FADBAFC;
      4'd3:  v = 34'h007F56EA6;
      4'd4:  v = 34'h003FEAB76;
      4'd5:  v = 34'h001FFD55B;
      4'd6:  v = 34'h000FFFAAA;
      4'd7:  v = 34'h0007FFF55;
      4'd8:  v = 34'h0003FFFEA;
      4'd9:  v = 34'h0001FFFFD;
      4'd10: v = 34'h0000FFFFF;
      4'd11: v = 34'h00007FFFF;
      4'd12: v = 34'h00003FFFF;
      4'd13: v = 34'h00001FFFF;
      4'd14: v = 34'h00000FFFF;
      4'd15: v = 34'h000007FFF;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/landmark_association_gate.sv]
// ---------------------------------------------------------------------------
// landmark_association_gate
// Landmark table with a gated nearest-neighbour search on measurements.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start_i; the request is taken at a
//   clock edge where start_i is high and busy_o is low. Every request gives
//   exactly one response on rsp_o, marked by done_o for one cycle; the
//   receiver cannot stall it.
//   Load, clear and unknown commands respond in the cycle after acceptance,
//   and busy_o stays low, so a new request may follow at once.
//   A query runs the 16-step CORDIC (one rotation a cycle), one multiply and
//   one add stage, then scans the table one entry a cycle through a 4-stage
//   read/abs/square/compare pipeline. It responds once every stored
//   landmark has passed the pipeline, and busy_o falls in the same cycle
//   that done_o marks the response.
//   Configuration: cfg_valid_i/cfg_data_i write the gate radius (unsigned Q15.16);
//   cfg_ready_o is always high. Write it only while the block is idle.
//   Reset empties the table (fill count to zero) and sets the radius to one
//   metre. Memory contents are not cleared; entries above the fill count are
//   never read.
// ---------------------------------------------------------------------------
`default_nettype none
`include "landmark_association_gate_macros.svh"
module landmark_association_gate #(
  parameter int unsigned MaxLandmarks = lag_pkg::MaxLandmarksDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire lag_pkg::lag_req_t   req_i,
  output logic                     done_o,
  output lag_pkg::lag_rsp_t        rsp_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [lag_pkg::GateWidth-1:0] cfg_data_i
);
  import lag_pkg::*;

  localparam int unsigned IW = (MaxLandmarks > 1) ? $clog2(MaxLandmarks) : 1;
  localparam int unsigned CW = $clog2(MaxLandmarks + 1);

  lag_state_e state_q, state_d;
  logic [CW-1:0] count_q;
  logic [GateWidth-1:0] gate_q;
  logic [2*GateWidth-1:0] gate_sq_q;
  logic done_q;
  lag_rsp_t rsp_q;

  logic accept, is_query, full;
  logic cordic_start, cordic_done, scan_done;
  logic signed [WorldWidth-1:0] wx, wy;
  logic found;
  logic signed [31:0] mx, my;
  logic [IW-1:0] midx;
  logic [IW+5:0] midx_ext;
  logic wr_en;

  assign accept   = start_i & ~busy_o;
  assign is_query = (req_i.cmd == CMD_QUERY);
  assign full     = (count_q >= CW'(MaxLandmarks));
  assign wr_en    = accept & (req_i.cmd == CMD_LOAD) & ~full;
  assign midx_ext = {6'b0, midx};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept && is_query) state_d = ST_CORDIC;
      ST_CORDIC: if (cordic_done) state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy_o       = 1'b1;
    cordic_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o       = 1'b0;
        cordic_start = start_i & is_query;
      end
      ST_CORDIC: busy_o = 1'b1;
      ST_SCAN:   busy_o = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      gate_q  <= GateReset;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) gate_q <= cfg_data_i;
      // Advance the fill count on a load into a table with room, drop it to zero on a clear.
      if (wr_en) begin
        count_q <= count_q + CW'(1);
      end else if (accept && req_i.cmd == CMD_CLEAR) begin
        count_q <= '0;
      end
      done_q <= (accept & ~is_query) | scan_done;
    end
  end

  // Response register and radius square; payload needs no reset.
  always_ff @(posedge clk_i) begin
    gate_sq_q <= gate_q * gate_q;
    if (accept && !is_query) begin
      rsp_q.status      <= (req_i.cmd == CMD_LOAD) & full;
      rsp_q.found       <= 1'b0;
      rsp_q.match_x     <= '0;
      rsp_q.match_y     <= '0;
      rsp_q.match_index <= '0;
    end else if (scan_done) begin
      rsp_q.status      <= 1'b0;
      rsp_q.found       <= found;
      rsp_q.match_x     <= found ? mx : '0;
      rsp_q.match_y     <= found ? my : '0;
      rsp_q.match_index <= found ? midx_ext[5:0] : '0;
    end
  end

  lag_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .req_i   (req_i),
    .done_o  (cordic_done),
    .wx_o    (wx),
    .wy_o    (wy)
  );

  lag_scan #(
    .MaxLandmarks (MaxLandmarks)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (count_q[IW-1:0]),
    .wr_x_i      (req_i.mark_x),
    .wr_y_i      (req_i.mark_y),
    .start_i     (cordic_done),
    .count_i     (count_q),
    .gate_i      (gate_q),
    .gate_sq_i   (gate_sq_q),
    .wx_i        (wx),
    .wy_i        (wy),
    .done_o      (scan_done),
    .found_o     (found),
    .match_x_o   (mx),
    .match_y_o   (my),
    .match_idx_o (midx)
  );

  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

  `LAG_ASSERT(a_count_bound, count_q <= CW'(MaxLandmarks), "fill count beyond table")
  `LAG_ASSERT_IMP(a_scan_state, scan_done, state_q == ST_SCAN, "scan ended outside scan")
  `LAG_ASSERT_IMP(a_cordic_state, cordic_done, state_q == ST_CORDIC, "cordic out of phase")
  `LAG_ASSERT_NXT(a_scan_resp, scan_done, done_o, "query response missing")
  `LAG_ASSERT_IMP(a_found_status, done_o && rsp_o.found, !rsp_o.status, "found with drop")

endmodule
`default_nettype wire

[rtl/core/lag_cordic.sv]
// ---------------------------------------------------------------------------
// lag_cordic
// Iterative sine/cosine and conversion of a range/bearing to world position.
// ---------------------------------------------------------------------------
`default_nettype none
module lag_cordic (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire lag_pkg::lag_req_t       req_i,
  output logic                         done_o,
  output logic signed [lag_pkg::WorldWidth-1:0] wx_o,
  output logic signed [lag_pkg::WorldWidth-1:0] wy_o
);
  import lag_pkg::*;

  lag_phase_e ph_q, ph_d;
  logic [3:0] step_q;
  logic signed [CordicWidth-1:0] x_q, y_q, z_q;
  logic neg_q;
  logic signed [31:0] px_q, py_q;
  logic [30:0] rng_q;
  logic signed [65:0] prx_q, pry_q;
  logic signed [WorldWidth-1:0] wx_q, wy_q;

  logic signed [17:0] ang0, ang1, ang2;
  logic neg;
  logic signed [CordicWidth-1:0] xs, ys, at, cx, cy;
  logic signed [65:0] rx, ry;
  logic signed [65:0] rnd_x, rnd_y;

  always_comb begin
    ang0 = 18'(req_i.pose_heading) + 18'(req_i.meas_bearing);
    ang1 = ang0;
    if (ang1 > PiQ13) begin
      ang1 = ang1 - TwoPiQ13;
    end
    if (ang1 < -PiQ13) begin
      ang1 = ang1 + TwoPiQ13;
    end
    ang2 = ang1;
    neg  = 1'b0;
    if (ang1 > HalfPiQ13) begin
      ang2 = ang1 - PiQ13;
      neg  = 1'b1;
    end else if (ang1 < -HalfPiQ13) begin
      ang2 = ang1 + PiQ13;
      neg  = 1'b1;
    end
  end

  always_comb begin
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    at = $signed(atan_q30(step_q));
    cx = neg_q ? -x_q : x_q;
    cy = neg_q ? -y_q : y_q;
    rx = $signed({1'b0, rng_q}) * cx;
    ry = $signed({1'b0, rng_q}) * cy;
    rnd_x = (prx_q + 66'sd536870912) >>> 30;
    rnd_y = (pry_q + 66'sd536870912) >>> 30;
  end

  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      PH_IDLE: if (start_i) ph_d = PH_ROT;
      PH_ROT:  if (step_q == 4'(CordicSteps - 1)) ph_d = PH_MUL;
      PH_MUL:  ph_d = PH_ADD;
      PH_ADD:  ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      step_q <= '0;
    end else begin
      ph_q <= ph_d;
      if (ph_q == PH_ROT) begin
        step_q <= step_q + 4'd1;
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          x_q   <= CordicGain;
          y_q   <= '0;
          z_q   <= CordicWidth'(ang2) <<< 17;
          neg_q <= neg;
          px_q  <= req_i.pose_x;
          py_q  <= req_i.pose_y;
          rng_q <= req_i.meas_range;
        end
      end
      PH_ROT: begin
        if (!z_q[CordicWidth-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      PH_MUL: begin
        prx_q <= rx;
        pry_q <= ry;
      end
      PH_ADD: begin
        wx_q <= WorldWidth'(px_q) + rnd_x[WorldWidth-1:0];
        wy_q <= WorldWidth'(py_q) + rnd_y[WorldWidth-1:0];
      end
      default: ;
    endcase
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (ph_q == PH_ADD);
    end
  end

  assign done_o = done_q;
  assign wx_o   = wx_q;
  assign wy_o   = wy_q;

endmodule
`default_nettype wire

[rtl/core/lag_scan.sv]
// ---------------------------------------------------------------------------
// lag_scan
// Landmark memory and pipelined gated nearest-neighbour scan.
// ---------------------------------------------------------------------------
`default_nettype none
module lag_scan #(
  parameter int unsigned MaxLandmarks = lag_pkg::MaxLandmarksDef,
  localparam int unsigned IW = (MaxLandmarks > 1) ? $clog2(MaxLandmarks) : 1,
  localparam int unsigned CW = $clog2(MaxLandmarks + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     wr_en_i,
  input  wire logic [IW-1:0]            wr_addr_i,
  input  wire logic signed [31:0]       wr_x_i,
  input  wire logic signed [31:0]       wr_y_i,
  input  wire logic                     start_i,
  input  wire logic [CW-1:0]            count_i,
  input  wire logic [lag_pkg::GateWidth-1:0] gate_i,
  input  wire logic [2*lag_pkg::GateWidth-1:0] gate_sq_i,
  input  wire logic signed [lag_pkg::WorldWidth-1:0] wx_i,
  input  wire logic signed [lag_pkg::WorldWidth-1:0] wy_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic signed [31:0]            match_x_o,
  output logic signed [31:0]            match_y_o,
  output logic [IW-1:0]                 match_idx_o
);
  import lag_pkg::*;

  localparam int unsigned DW = WorldWidth + 1;
  localparam int unsigned GW = GateWidth;

  logic signed [31:0] mem_x [MaxLandmarks];
  logic signed [31:0] mem_y [MaxLandmarks];

  logic          run_q, issue_q;
  logic [IW-1:0] addr_q;
  logic          v1_q, v2_q, v3_q;
  logic [IW-1:0] i1_q, i2_q, i3_q;
  logic signed [31:0] rx_q, ry_q, x2_q, y2_q, x3_q, y3_q;
  logic          in2_q, in3_q;
  logic [GW-1:0] ax_q, ay_q;
  logic [2*GW-1:0] sx_q, sy_q;
  logic [2*GW-1:0] best_q;
  logic          found_q;
  logic signed [31:0] mx_q, my_q;
  logic [IW-1:0] mi_q;

  logic signed [DW-1:0] dx, dy, adx, ady;
  logic [2*GW:0] d2;
  logic last;

  always_comb begin
    dx  = DW'(wx_i) - DW'(rx_q);
    dy  = DW'(wy_i) - DW'(ry_q);
    adx = dx[DW-1] ? -dx : dx;
    ady = dy[DW-1] ? -dy : dy;
    d2  = {1'b0, sx_q} + {1'b0, sy_q};
    last = (CW'(addr_q) == count_i - CW'(1));
  end

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_x[wr_addr_i] <= wr_x_i;
      mem_y[wr_addr_i] <= wr_y_i;
    end
    rx_q <= mem_x[addr_q];
    ry_q <= mem_y[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      issue_q <= 1'b0;
      addr_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q <= issue_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (start_i) begin
        run_q   <= 1'b1;
        issue_q <= (count_i != '0);
        addr_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (done_o) run_q <= 1'b0;
        if (issue_q) begin
          addr_q <= addr_q + IW'(1);
          if (last) issue_q <= 1'b0;
        end
        if (v3_q && in3_q && (d2 <= {1'b0, best_q})) found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q <= addr_q;
    i2_q <= i1_q;
    x2_q <= rx_q;
    y2_q <= ry_q;
    in2_q <= (adx <= DW'(gate_i)) && (ady <= DW'(gate_i));
    ax_q  <= adx[GW-1:0];
    ay_q  <= ady[GW-1:0];
    i3_q  <= i2_q;
    x3_q  <= x2_q;
    y3_q  <= y2_q;
    in3_q <= in2_q;
    sx_q  <= ax_q * ax_q;
    sy_q  <= ay_q * ay_q;
    if (start_i) begin
      best_q <= gate_sq_i;
    end else if (v3_q && in3_q && (d2 <= {1'b0, best_q})) begin
      best_q <= d2[2*GW-1:0];
      mx_q   <= x3_q;
      my_q   <= y3_q;
      mi_q   <= i3_q;
    end
  end

  assign done_o      = run_q & ~start_i & ~issue_q & ~v1_q & ~v2_q & ~v3_q;
  assign found_o     = found_q;
  assign match_x_o   = mx_q;
  assign match_y_o   = my_q;
  assign match_idx_o = mi_q;

endmodule
`default_nettype wire
